// File: rtl/pir_pkg.sv
// ----------------------------------------------------------------------------
// pir_pkg
// Shared constants, types and control structs for the palette lookup block.
// ----------------------------------------------------------------------------
package pir_pkg;

    // Palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int IDX_W       = 8;

    // Pixel statistics
    localparam int MAX_PIXELS  = 1048576;
    localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W       = $clog2(64'd255 * MAX_PIXELS + 64'd1);

    // Q0.16 average
    localparam int Q_W         = 16;
    localparam int ITER_W      = $clog2(Q_W);

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    // Input item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Controller -> datapath
    typedef struct packed {
        logic  load;
        logic  read;
        logic  lookup;
        logic  div_start;
        logic  emit;
        t_chan ch;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic div_done;
        logic out_free;
        logic last;
    } t_status;

endpackage

// File: rtl/pir_div.sv
// ----------------------------------------------------------------------------
// pir_div
// Restoring divider, one quotient bit per cycle: floor(sum*65535/(255*count)).
// ----------------------------------------------------------------------------
module pir_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pir_pkg::SUM_W-1:0]  i_sum,
    input  logic [pir_pkg::CNT_W-1:0]  i_count,
    output logic                       o_done,
    output logic [pir_pkg::Q_W-1:0]    o_quot
);
    import pir_pkg::*;

    localparam int NUM_W     = SUM_W + Q_W;
    localparam int DEN_RAW_W = CNT_W + 8;

    logic [SUM_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_lo;
    logic [SUM_W-1:0]  r_den;
    logic [Q_W-1:0]    r_q;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;
    logic              r_done;

    logic [NUM_W-1:0]     w_numer;
    logic [DEN_RAW_W-1:0] w_den_raw;
    logic [SUM_W:0]       w_trial;
    logic [SUM_W:0]       w_diff;
    logic                 w_ge;

    // sum*65535 = (sum<<16) - sum, den = (count<<8) - count
    assign w_numer   = {i_sum, {Q_W{1'b0}}} - {{Q_W{1'b0}}, i_sum};
    assign w_den_raw = {i_count, 8'b0} - {8'b0, i_count};

    // one shift-subtract step
    assign w_trial = {r_rem, r_lo[Q_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial remainder; high part of numerator is below den
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_numer[NUM_W-1:Q_W];
            r_lo  <= w_numer[Q_W-1:0];
            r_den <= SUM_W'(w_den_raw);
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
            r_lo  <= {r_lo[Q_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '0 : r_q;

endmodule

// File: rtl/pir_dp.sv
// ----------------------------------------------------------------------------
// pir_dp
// Datapath: config registers, palette memory, accumulators, averages, output.
// ----------------------------------------------------------------------------
module pir_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pir_pkg::t_cmd                   i_cmd,
    output pir_pkg::t_status                o_status,
    input  logic                            i_cfg_we,
    input  logic [pir_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                            i_cfg_data,
    input  logic [pir_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [7:0]                      i_entry_red,
    input  logic [7:0]                      i_entry_green,
    input  logic [7:0]                      i_entry_blue,
    input  logic [7:0]                      i_entry_alpha,
    input  logic [pir_pkg::IDX_W-1:0]       i_pixel_index,
    input  logic                            i_last_pixel,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [7:0]                      o_red,
    output logic [7:0]                      o_green,
    output logic [7:0]                      o_blue,
    output logic [7:0]                      o_alpha,
    output logic                            o_image_done,
    output logic [pir_pkg::Q_W-1:0]         o_average_red,
    output logic [pir_pkg::Q_W-1:0]         o_average_green,
    output logic [pir_pkg::Q_W-1:0]         o_average_blue,
    output logic                            o_has_transparency
);
    import pir_pkg::*;

    // config
    logic r_transparent;
    logic r_format;

    // palette memory
    logic [31:0] r_mem [PAL_ENTRIES];
    logic [31:0] r_rd_data;

    // pixel in flight
    logic r_px_oob;
    logic r_px_top;
    logic r_px_last;
    logic [7:0] r_pix_red, r_pix_green, r_pix_blue, r_pix_alpha;

    // image statistics
    logic [SUM_W-1:0] r_sum_red, r_sum_green, r_sum_blue;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_alpha_and;
    logic [Q_W-1:0]   r_avg_red, r_avg_green, r_avg_blue;

    // output register
    logic           r_out_valid;
    logic [7:0]     r_o_red, r_o_green, r_o_blue, r_o_alpha;
    logic           r_o_done;
    logic [Q_W-1:0] r_o_avg_red, r_o_avg_green, r_o_avg_blue;
    logic           r_o_trans;

    logic             w_load_ok;
    logic             w_rd_oob;
    logic [PAL_AW-1:0] w_wr_addr;
    logic [PAL_AW-1:0] w_rd_addr;
    logic [7:0]       w_alpha_in;
    logic [7:0]       w_r, w_g, w_b, w_a;
    logic [SUM_W-1:0] w_div_sum;
    logic             w_div_done;
    logic [Q_W-1:0]   w_quot;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transparent <= 1'b0;
            r_format      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRANSPARENT: r_transparent <= i_cfg_data;
                CFG_FORMAT:      r_format      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // palette write and registered read
    assign w_load_ok  = ({1'b0, i_entry_index} < (IDX_W + 1)'(PAL_ENTRIES));
    assign w_rd_oob   = ({1'b0, i_pixel_index} >= (IDX_W + 1)'(PAL_ENTRIES));
    assign w_wr_addr  = i_entry_index[PAL_AW-1:0];
    assign w_rd_addr  = i_pixel_index[PAL_AW-1:0];
    assign w_alpha_in = r_format ? i_entry_alpha : FULL_BYTE;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_mem[w_wr_addr] <= {i_entry_red, i_entry_green, i_entry_blue, w_alpha_in};
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // pixel tags captured with the read
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_px_oob  <= w_rd_oob;
            r_px_top  <= (i_pixel_index == IDX_W'(PAL_ENTRIES - 1));
            r_px_last <= i_last_pixel;
        end
    end

    // color and alpha of the looked-up entry
    always_comb begin
        w_r = r_px_oob ? 8'h00 : r_rd_data[31:24];
        w_g = r_px_oob ? 8'h00 : r_rd_data[23:16];
        w_b = r_px_oob ? 8'h00 : r_rd_data[15:8];
        w_a = r_px_oob ? 8'h00 : r_rd_data[7:0];
        if (r_transparent && !r_format && r_px_top) begin
            w_a = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_pix_red   <= w_r;
            r_pix_green <= w_g;
            r_pix_blue  <= w_b;
            r_pix_alpha <= w_a;
        end
    end

    // accumulators; saturate at the pixel limit, clear after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_cnt       <= '0;
            r_alpha_and <= FULL_BYTE;
        end else if (i_cmd.lookup) begin
            if (r_cnt < CNT_W'(MAX_PIXELS)) begin
                r_sum_red   <= r_sum_red + SUM_W'(w_r);
                r_sum_green <= r_sum_green + SUM_W'(w_g);
                r_sum_blue  <= r_sum_blue + SUM_W'(w_b);
                r_cnt       <= r_cnt + 1'b1;
                r_alpha_and <= r_alpha_and & w_a;
            end
        end else if (i_cmd.emit && r_px_last) begin
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_cnt       <= '0;
            r_alpha_and <= FULL_BYTE;
        end
    end

    // channel averages through the shared divider
    always_comb begin
        unique case (i_cmd.ch)
            CH_RED:   w_div_sum = r_sum_red;
            CH_GREEN: w_div_sum = r_sum_green;
            CH_BLUE:  w_div_sum = r_sum_blue;
            default:  w_div_sum = r_sum_red;
        endcase
    end

    pir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (w_div_sum),
        .i_count (r_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            unique case (i_cmd.ch)
                CH_RED:   r_avg_red   <= w_quot;
                CH_GREEN: r_avg_green <= w_quot;
                CH_BLUE:  r_avg_blue  <= w_quot;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_red       <= r_pix_red;
            r_o_green     <= r_pix_green;
            r_o_blue      <= r_pix_blue;
            r_o_alpha     <= r_pix_alpha;
            r_o_done      <= r_px_last;
            r_o_avg_red   <= r_px_last ? r_avg_red   : '0;
            r_o_avg_green <= r_px_last ? r_avg_green : '0;
            r_o_avg_blue  <= r_px_last ? r_avg_blue  : '0;
            r_o_trans     <= r_px_last && r_transparent && (r_alpha_and != FULL_BYTE);
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = r_px_last;

    assign o_out_valid        = r_out_valid;
    assign o_red              = r_o_red;
    assign o_green            = r_o_green;
    assign o_blue             = r_o_blue;
    assign o_alpha            = r_o_alpha;
    assign o_image_done       = r_o_done;
    assign o_average_red      = r_o_avg_red;
    assign o_average_green    = r_o_avg_green;
    assign o_average_blue     = r_o_avg_blue;
    assign o_has_transparency = r_o_trans;

endmodule

// File: rtl/pir_ctrl.sv
// ----------------------------------------------------------------------------
// pir_ctrl
// Controller: sequences palette loads, pixel lookups, averages and output.
// ----------------------------------------------------------------------------
module pir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_action,
    output logic              o_in_ready,
    output pir_pkg::t_cmd     o_cmd,
    input  pir_pkg::t_status  i_status
);
    import pir_pkg::*;

    t_state r_state, n_state;
    t_chan  r_ch, n_ch;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= CH_RED;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_ch            = r_ch;
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.read      = 1'b0;
        o_cmd.lookup    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.ch        = r_ch;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ACT_PIXEL) begin
                        o_cmd.read = 1'b1;
                        n_state    = S_LOOKUP;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_ch         = CH_RED;
                n_state      = i_status.last ? S_DIV_START : S_EMIT;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    unique case (r_ch)
                        CH_RED: begin
                            n_ch    = CH_GREEN;
                            n_state = S_DIV_START;
                        end
                        CH_GREEN: begin
                            n_ch    = CH_BLUE;
                            n_state = S_DIV_START;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/palette_index_to_rgba.sv
// ----------------------------------------------------------------------------
// palette_index_to_rgba
// Indexed-color palette lookup to RGBA with per-image channel averages.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): load items (action 0) write one
// palette entry; pixel items (action 1) look up one index. Output channel
// (o_out_valid / i_out_ready): one result per pixel, none per load.
// Config port: i_cfg_we, i_cfg_index (0 transparent mode, 1 color format),
// i_cfg_data; write only while the block is idle.
// Sequence: a load writes its entry and leaves the block ready for the next
// item. A pixel is taken by the 256-entry palette memory (registered read),
// looked up and accumulated, then loaded into the output register; only then
// is the next item accepted. The last pixel of an image adds three
// one-bit-per-cycle divisions (one shared divider) before its output.
// Reset clears config, accumulators and control; palette contents are
// undefined until loaded. When the receiver stalls, the result holds in the
// output register; loads are still taken, and one more pixel is accepted and
// then waits for the register to drain.
// ----------------------------------------------------------------------------
module palette_index_to_rgba (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [pir_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [7:0]                    i_entry_red,
    input  logic [7:0]                    i_entry_green,
    input  logic [7:0]                    i_entry_blue,
    input  logic [7:0]                    i_entry_alpha,
    input  logic [pir_pkg::IDX_W-1:0]     i_pixel_index,
    input  logic                          i_last_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    output logic [7:0]                    o_alpha,
    output logic                          o_image_done,
    output logic [pir_pkg::Q_W-1:0]       o_average_red,
    output logic [pir_pkg::Q_W-1:0]       o_average_green,
    output logic [pir_pkg::Q_W-1:0]       o_average_blue,
    output logic                          o_has_transparency
);
    import pir_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    pir_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_entry_index      (i_entry_index),
        .i_entry_red        (i_entry_red),
        .i_entry_green      (i_entry_green),
        .i_entry_blue       (i_entry_blue),
        .i_entry_alpha      (i_entry_alpha),
        .i_pixel_index      (i_pixel_index),
        .i_last_pixel       (i_last_pixel),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .o_alpha            (o_alpha),
        .o_image_done       (o_image_done),
        .o_average_red      (o_average_red),
        .o_average_green    (o_average_green),
        .o_average_blue     (o_average_blue),
        .o_has_transparency (o_has_transparency)
    );

endmodule

// File: rtl/pir_checker.sv
// ----------------------------------------------------------------------------
// pir_checker
// Port-level checks on the palette lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module pir_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_action,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [7:0]                    o_red,
    input logic [7:0]                    o_alpha,
    input logic                          o_image_done,
    input logic [pir_pkg::Q_W-1:0]       o_average_red,
    input logic [pir_pkg::Q_W-1:0]       o_average_green,
    input logic [pir_pkg::Q_W-1:0]       o_average_blue,
    input logic                          o_has_transparency
);
    import pir_pkg::*;

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_red) && $stable(o_alpha) && $stable(o_image_done))
        else $error("stalled result changed");

    // summary fields are zero except on the last pixel
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_image_done |->
            o_average_red == '0 && o_average_green == '0 &&
            o_average_blue == '0 && !o_has_transparency)
        else $error("summary fields set on a non-final pixel");

    // a pixel transfer occupies the block for the following cycle
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == ACT_PIXEL |=> !o_in_ready)
        else $error("input taken while a pixel is in flight");

    // a load transfer never creates a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == ACT_LOAD && !o_out_valid |=>
            !o_out_valid)
        else $error("result after a palette load");

endmodule

bind palette_index_to_rgba pir_checker u_pir_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_action           (i_action),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_red              (o_red),
    .o_alpha            (o_alpha),
    .o_image_done       (o_image_done),
    .o_average_red      (o_average_red),
    .o_average_green    (o_average_green),
    .o_average_blue     (o_average_blue),
    .o_has_transparency (o_has_transparency)
);

// File: verif/palette_index_to_rgba_tb.sv
// ----------------------------------------------------------------------------
// palette_index_to_rgba_tb
// Self-checking bench for the palette lookup block. Palette loads and pixel
// items go in over the input channel. A predictor in the bench tracks the
// palette, per-image sums, pixel count and alpha AND. It queues one
// expected RGBA result per pixel. The output monitor checks every result
// field by field. The run covers directed corner cases, a full palette
// fill, and random traffic under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module palette_index_to_rgba_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pir_pkg::*;

    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic             action;
        logic [IDX_W-1:0] entry_index;
        logic [7:0]       entry_red;
        logic [7:0]       entry_green;
        logic [7:0]       entry_blue;
        logic [7:0]       entry_alpha;
        logic [IDX_W-1:0] pixel_index;
        logic             last_pixel;
    } t_pal_item;

    typedef struct {
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [7:0]     alpha;
        logic           image_done;
        logic [Q_W-1:0] avg_red;
        logic [Q_W-1:0] avg_green;
        logic [Q_W-1:0] avg_blue;
        logic           has_transparency;
    } t_rgba_result;

    // DUT signals
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TRANSPARENT;
    logic                 i_cfg_data = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_action = ACT_LOAD;
    logic [IDX_W-1:0]     i_entry_index = '0;
    logic [7:0]           i_entry_red = '0;
    logic [7:0]           i_entry_green = '0;
    logic [7:0]           i_entry_blue = '0;
    logic [7:0]           i_entry_alpha = '0;
    logic [IDX_W-1:0]     i_pixel_index = '0;
    logic                 i_last_pixel = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_red;
    logic [7:0]           o_green;
    logic [7:0]           o_blue;
    logic [7:0]           o_alpha;
    logic                 o_image_done;
    logic [Q_W-1:0]       o_average_red;
    logic [Q_W-1:0]       o_average_green;
    logic [Q_W-1:0]       o_average_blue;
    logic                 o_has_transparency;

    // Predictor state
    logic [31:0]     palette_copy [PAL_ENTRIES];
    bit              palette_loaded [PAL_ENTRIES];
    longint unsigned red_sum = 0;
    longint unsigned green_sum = 0;
    longint unsigned blue_sum = 0;
    int unsigned     pixel_count = 0;
    logic [7:0]      alpha_and_acc = FULL_BYTE;
    logic            transp_mode = 1'b0;
    logic            rgba_format = 1'b0;

    t_rgba_result expected_rgba [$];
    int           n_errors = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           stall_cycles = 0;

    palette_index_to_rgba uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_entry_index      (i_entry_index),
        .i_entry_red        (i_entry_red),
        .i_entry_green      (i_entry_green),
        .i_entry_blue       (i_entry_blue),
        .i_entry_alpha      (i_entry_alpha),
        .i_pixel_index      (i_pixel_index),
        .i_last_pixel       (i_last_pixel),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .o_alpha            (o_alpha),
        .o_image_done       (o_image_done),
        .o_average_red      (o_average_red),
        .o_average_green    (o_average_green),
        .o_average_blue     (o_average_blue),
        .o_has_transparency (o_has_transparency)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor(sum * 65535 / (255 * count)), saturated
    function automatic logic [Q_W-1:0] q16_mean(input longint unsigned total,
                                                input int unsigned n);
        longint unsigned q;
        if (n == 0) return '0;
        q = (total * 64'd65535) / (64'd255 * n);
        return (q > 64'd65535) ? 16'hFFFF : q[Q_W-1:0];
    endfunction

    // Predictor: update palette/accumulators and queue the expected pixel
    task automatic lookup_rgba(input t_pal_item it);
        logic [31:0]  entry;
        t_rgba_result res;
        if (it.action == ACT_LOAD) begin
            // format is sampled when the entry is written
            palette_copy[it.entry_index] = {it.entry_red, it.entry_green, it.entry_blue,
                                            rgba_format ? it.entry_alpha : FULL_BYTE};
            palette_loaded[it.entry_index] = 1'b1;
        end else begin
            entry = palette_copy[it.pixel_index];
            res = '{default: '0};
            res.red   = entry[31:24];
            res.green = entry[23:16];
            res.blue  = entry[15:8];
            res.alpha = entry[7:0];
            // last entry is see-through in RGB format with transparency on
            if (transp_mode && !rgba_format && it.pixel_index == IDX_W'(PAL_ENTRIES - 1))
                res.alpha = '0;
            // past the pixel cap, pixels are translated but not accumulated
            if (pixel_count < MAX_PIXELS) begin
                red_sum       += 64'(res.red);
                green_sum     += 64'(res.green);
                blue_sum      += 64'(res.blue);
                alpha_and_acc &= res.alpha;
                pixel_count++;
            end
            if (it.last_pixel) begin
                res.image_done       = 1'b1;
                res.avg_red          = q16_mean(red_sum, pixel_count);
                res.avg_green        = q16_mean(green_sum, pixel_count);
                res.avg_blue         = q16_mean(blue_sum, pixel_count);
                res.has_transparency = transp_mode && (alpha_and_acc != FULL_BYTE);
                red_sum       = 0;
                green_sum     = 0;
                blue_sum      = 0;
                pixel_count   = 0;
                alpha_and_acc = FULL_BYTE;
            end
            expected_rgba.insert(expected_rgba.size(), res);
        end
    endtask

    // Item builders; fields the item does not use get random values
    function automatic t_pal_item load_item(input logic [7:0] idx, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a);
        t_pal_item it;
        it.action      = ACT_LOAD;
        it.entry_index = idx;
        it.entry_red   = r;
        it.entry_green = g;
        it.entry_blue  = b;
        it.entry_alpha = a;
        it.pixel_index = 8'($urandom_range(255));
        it.last_pixel  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_pal_item pixel_item(input logic [7:0] idx, input logic last);
        t_pal_item it;
        it.action      = ACT_PIXEL;
        it.entry_index = 8'($urandom_range(255));
        it.entry_red   = 8'($urandom_range(255));
        it.entry_green = 8'($urandom_range(255));
        it.entry_blue  = 8'($urandom_range(255));
        it.entry_alpha = 8'($urandom_range(255));
        it.pixel_index = idx;
        it.last_pixel  = last;
        return it;
    endfunction

    function automatic t_pal_item random_load();
        return load_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
    endfunction

    // Sender: optional idle gap, then hold valid until the transfer
    task automatic send_item(input t_pal_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= it.action;
        i_entry_index <= it.entry_index;
        i_entry_red   <= it.entry_red;
        i_entry_green <= it.entry_green;
        i_entry_blue  <= it.entry_blue;
        i_entry_alpha <= it.entry_alpha;
        i_pixel_index <= it.pixel_index;
        i_last_pixel  <= it.last_pixel;
        do @(posedge i_clk); while (!o_in_ready);
        lookup_rgba(it);
    endtask

    // Stop sending, wait for every pending result, then let the block settle
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_rgba.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_TRANSPARENT) transp_mode = val;
        else rgba_format = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Opaque RGB palette: black, white and mid entries, one-pixel images and a three-pixel one
    task automatic test_opaque_rgb();
        write_cfg(CFG_TRANSPARENT, 1'b0);
        write_cfg(CFG_FORMAT, 1'b0);
        // alpha given at load must be ignored in RGB format
        send_item(load_item(8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(load_item(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_item(load_item(8'd128, 8'h80, 8'h40, 8'h20, 8'h5A));
        send_item(pixel_item(8'd0, 1'b1));
        send_item(pixel_item(8'd255, 1'b1));
        send_item(pixel_item(8'd0, 1'b0));
        send_item(pixel_item(8'd255, 1'b0));
        send_item(pixel_item(8'd128, 1'b1));
        wait_for_results();
    endtask

    // Transparent entry: last index reads alpha 0 and raises the image flag
    task automatic test_transparent_entry();
        write_cfg(CFG_TRANSPARENT, 1'b1);
        send_item(pixel_item(8'd255, 1'b0));
        send_item(pixel_item(8'd0, 1'b1));
        send_item(pixel_item(8'd128, 1'b1));
        wait_for_results();
    endtask

    // RGBA format: stored alpha is used, last entry no longer forced clear
    task automatic test_rgba_alpha();
        write_cfg(CFG_FORMAT, 1'b1);
        send_item(load_item(8'd1, 8'h11, 8'h22, 8'h33, 8'h00));
        send_item(load_item(8'd254, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        send_item(pixel_item(8'd255, 1'b0));
        send_item(pixel_item(8'd254, 1'b1));
        send_item(pixel_item(8'd1, 1'b1));
        wait_for_results();
        // clear alpha with transparency off: flag stays low
        write_cfg(CFG_TRANSPARENT, 1'b0);
        send_item(pixel_item(8'd1, 1'b0));
        send_item(pixel_item(8'd254, 1'b1));
        wait_for_results();
    endtask

    // Load every entry in random order, half in each format
    task automatic test_palette_fill();
        logic [7:0] order [$];
        for (int i = 0; i < PAL_ENTRIES; i++) order.insert(order.size(), 8'(i));
        order.shuffle();
        send_idle_pct = 46;
        write_cfg(CFG_FORMAT, 1'b0);
        for (int i = 0; i < PAL_ENTRIES / 2; i++)
            send_item(load_item(order[i], 8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255))));
        wait_for_results();
        send_idle_pct = 0;
        write_cfg(CFG_FORMAT, 1'b1);
        for (int i = PAL_ENTRIES / 2; i < PAL_ENTRIES; i++)
            send_item(load_item(order[i], 8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255))));
        wait_for_results();
    endtask

    // Random mix of loads and pixels over loaded entries; occasional full pause
    task automatic run_traffic(input int n_items);
        logic [7:0] idx;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 20) begin
                send_item(random_load());
            end else begin
                if ($urandom_range(9) == 0) idx = 8'(PAL_ENTRIES - 1);
                else do idx = 8'($urandom_range(255)); while (!palette_loaded[idx]);
                send_item(pixel_item(idx, $urandom_range(9) == 0));
            end
            if ($urandom_range(49) == 0) wait_for_results();
        end
    endtask

    // Four idling mixes, each with its own register setting; images left open
    // across a phase boundary see the register change mid-image
    task automatic test_random_phases();
        int idle_mix [4]  = '{0, 46, 0, 23};
        int stall_mix [4] = '{0, 0, 46, 23};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            write_cfg(CFG_TRANSPARENT, p[0]);
            write_cfg(CFG_FORMAT, p[1]);
            run_traffic(75);
            wait_for_results();
        end
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Output monitor: every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_rgba_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rgba.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual rgba %h%h%h%h",
                         $time, o_red, o_green, o_blue, o_alpha);
                n_errors++;
            end else begin
                want = expected_rgba.pop_front();
                check_field("red", 16'(want.red), 16'(o_red));
                check_field("green", 16'(want.green), 16'(o_green));
                check_field("blue", 16'(want.blue), 16'(o_blue));
                check_field("alpha", 16'(want.alpha), 16'(o_alpha));
                check_field("image_done", 16'(want.image_done), 16'(o_image_done));
                check_field("average_red", want.avg_red, o_average_red);
                check_field("average_green", want.avg_green, o_average_green);
                check_field("average_blue", want.avg_blue, o_average_blue);
                check_field("has_transparency", 16'(want.has_transparency),
                            16'(o_has_transparency));
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results pending",
                         $time, expected_rgba.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_opaque_rgb();
        test_transparent_entry();
        test_rgba_alpha();
        test_palette_fill();
        test_random_phases();
        wait_for_results();
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
